// ===== sv/kia_pkg.sv =====
// Shared types and codes for the key/ID allocator.
`default_nettype none
package kia_pkg;

    typedef enum logic [1:0] {
        KIND_CREATE  = 2'd0,
        KIND_GET     = 2'd1,
        KIND_RESTORE = 2'd2,
        KIND_RESERVE = 2'd3
    } kind_t;

    typedef enum logic [2:0] {
        ST_OK          = 3'd0,
        ST_CREATE_REJ  = 3'd1,
        ST_OUT_OF_SPAN = 3'd2,
        ST_WRONG_MARK  = 3'd3,
        ST_EMPTY       = 3'd4,
        ST_FULL        = 3'd5
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_FILL,
        S_GET_MARK,
        S_GET_CHK,
        S_MARK_CHK
    } state_t;

    localparam logic CFG_START_KEY = 1'b0;
    localparam logic CFG_END_KEY   = 1'b1;

endpackage
`default_nettype wire

// ===== sv/key_id_allocator.sv =====
// Top level of the key/ID allocator: control, span registers and free-list queue.
//
// One command is taken at a time while busy is low; its result appears for one cycle with
// done high and cannot be held off. Rejected creates, gets on an empty queue and restores
// or reserves outside the span answer in the cycle after the transfer. Restore and reserve
// read the issued mark, then check it and write it back. A get reads each queue entry it
// examines and then that entry's issued mark, and answers once an entry passes or the
// queue runs empty; stale entries are what stretch it. A successful create sweeps both
// memories, one offset a cycle, and answers when the sweep ends; no clearing pass is
// needed after reset.
`default_nettype none
module key_id_allocator #(
    parameter int MAX_KEYS    = 1024,
    parameter int QUEUE_DEPTH = 2048
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic        cfg_index,
    input  wire logic [31:0] cfg_data,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [1:0]  kind,
    input  wire logic [31:0] key,
    output logic             done,
    output logic [31:0]      issued_key,
    output logic [2:0]       status,
    output logic [9:0]       free_count
);

    localparam int OFF_W  = $clog2(MAX_KEYS);
    localparam int QA_W   = $clog2(QUEUE_DEPTH);
    localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);

    kia_pkg::state_t  state_reg, state_next;
    kia_pkg::kind_t   kind_reg, kind_next;
    kia_pkg::status_t status_reg, status_next;
    logic             done_reg, done_next;
    logic [31:0]      issued_reg, issued_next;
    logic [31:0]      start_key_reg, end_key_reg;
    logic [31:0]      span_base_reg, span_base_next;
    logic [OFF_W-1:0] span_size_reg, span_size_next;
    logic [OFF_W-1:0] free_reg, free_next;
    logic [OFF_W-1:0] cnt_reg, cnt_next;
    logic [OFF_W-1:0] off_reg, off_next;
    logic [QA_W-1:0]  head_reg, head_next;
    logic [QA_W-1:0]  tail_reg, tail_next;
    logic [FILL_W-1:0] fill_reg, fill_next;
    logic             set_up_reg, set_up_next;

    logic             q_we;
    logic [QA_W-1:0]  q_waddr;
    logic [OFF_W-1:0] q_wdata;
    logic [OFF_W-1:0] q_rdata;
    logic             m_we;
    logic [OFF_W-1:0] m_waddr;
    logic [0:0]       m_wdata;
    logic [OFF_W-1:0] m_raddr;
    logic [0:0]       m_rdata;

    logic [32:0]      size_diff;
    logic [32:0]      key_diff;
    logic             create_bad;
    logic             key_in_span;
    logic [OFF_W-1:0] key_off;
    logic [QA_W-1:0]  head_inc;
    logic [QA_W-1:0]  tail_inc;
    logic [OFF_W-1:0] free_dec;

    kia_ram #(.WIDTH(OFF_W), .DEPTH(QUEUE_DEPTH), .ADDR_W(QA_W)) u_queue (
        .clk   (clk),
        .we    (q_we),
        .waddr (q_waddr),
        .wdata (q_wdata),
        .raddr (head_reg),
        .rdata (q_rdata)
    );

    kia_ram #(.WIDTH(1), .DEPTH(MAX_KEYS), .ADDR_W(OFF_W)) u_mark (
        .clk   (clk),
        .we    (m_we),
        .waddr (m_waddr),
        .wdata (m_wdata),
        .raddr (m_raddr),
        .rdata (m_rdata)
    );

    assign size_diff  = {1'b0, end_key_reg} - {1'b0, start_key_reg};
    assign create_bad = set_up_reg || (fill_reg != '0) || (start_key_reg == '0)
                        || size_diff[32] || (size_diff == '0)
                        || (size_diff >= 33'(MAX_KEYS - 1))
                        || (size_diff >= 33'(QUEUE_DEPTH));
    assign key_diff    = {1'b0, key} - {1'b0, span_base_reg};
    assign key_in_span = !key_diff[32] && (key_diff[31:0] < 32'(span_size_reg));
    assign key_off     = key_diff[OFF_W-1:0];
    assign head_inc    = (head_reg == QA_W'(QUEUE_DEPTH - 1)) ? '0 : head_reg + 1'b1;
    assign tail_inc    = (tail_reg == QA_W'(QUEUE_DEPTH - 1)) ? '0 : tail_reg + 1'b1;
    assign free_dec    = (free_reg != '0) ? free_reg - 1'b1 : free_reg;

    assign busy       = (state_reg != kia_pkg::S_IDLE);
    assign done       = done_reg;
    assign issued_key = issued_reg;
    assign status     = status_reg;
    assign free_count = 10'(free_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_key_reg <= '0;
            end_key_reg   <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                kia_pkg::CFG_START_KEY: start_key_reg <= cfg_data;
                kia_pkg::CFG_END_KEY:   end_key_reg   <= cfg_data;
                default:                start_key_reg <= start_key_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= kia_pkg::S_IDLE;
            done_reg      <= 1'b0;
            span_base_reg <= '0;
            span_size_reg <= '0;
            free_reg      <= '0;
            head_reg      <= '0;
            tail_reg      <= '0;
            fill_reg      <= '0;
            set_up_reg    <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            done_reg      <= done_next;
            span_base_reg <= span_base_next;
            span_size_reg <= span_size_next;
            free_reg      <= free_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            fill_reg      <= fill_next;
            set_up_reg    <= set_up_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg   <= kind_next;
        status_reg <= status_next;
        issued_reg <= issued_next;
        cnt_reg    <= cnt_next;
        off_reg    <= off_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        kind_next      = kind_reg;
        status_next    = status_reg;
        done_next      = 1'b0;
        issued_next    = issued_reg;
        span_base_next = span_base_reg;
        span_size_next = span_size_reg;
        free_next      = free_reg;
        cnt_next       = cnt_reg;
        off_next       = off_reg;
        head_next      = head_reg;
        tail_next      = tail_reg;
        fill_next      = fill_reg;
        set_up_next    = set_up_reg;
        q_we           = 1'b0;
        q_waddr        = tail_reg;
        q_wdata        = off_reg;
        m_we           = 1'b0;
        m_waddr        = off_reg;
        m_wdata        = 1'b0;
        m_raddr        = key_off;

        case (state_reg)
            kia_pkg::S_IDLE:
            begin
                if (start)
                begin
                    kind_next = kia_pkg::kind_t'(kind);
                    case (kia_pkg::kind_t'(kind))
                        kia_pkg::KIND_CREATE:
                        begin
                            if (create_bad)
                            begin
                                done_next   = 1'b1;
                                status_next = kia_pkg::ST_CREATE_REJ;
                                issued_next = '0;
                            end
                            else
                            begin
                                span_base_next = start_key_reg;
                                span_size_next = OFF_W'(size_diff + 33'd1);
                                cnt_next       = '0;
                                state_next     = kia_pkg::S_FILL;
                            end
                        end
                        kia_pkg::KIND_GET:
                        begin
                            if (fill_reg == '0)
                            begin
                                done_next   = 1'b1;
                                status_next = kia_pkg::ST_EMPTY;
                                issued_next = '0;
                            end
                            else
                            begin
                                head_next  = head_inc;
                                fill_next  = fill_reg - 1'b1;
                                state_next = kia_pkg::S_GET_MARK;
                            end
                        end
                        default:
                        begin
                            if (!key_in_span)
                            begin
                                done_next   = 1'b1;
                                status_next = kia_pkg::ST_OUT_OF_SPAN;
                                issued_next = '0;
                            end
                            else
                            begin
                                off_next   = key_off;
                                state_next = kia_pkg::S_MARK_CHK;
                            end
                        end
                    endcase
                end
            end
            kia_pkg::S_FILL:
            begin
                q_we     = 1'b1;
                q_waddr  = QA_W'(cnt_reg);
                q_wdata  = cnt_reg;
                m_we     = 1'b1;
                m_waddr  = cnt_reg;
                m_wdata  = 1'b0;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == span_size_reg - 1'b1)
                begin
                    done_next   = 1'b1;
                    status_next = kia_pkg::ST_OK;
                    issued_next = '0;
                    head_next   = '0;
                    tail_next   = (32'(span_size_reg) >= 32'(QUEUE_DEPTH)) ? '0
                                  : QA_W'(span_size_reg);
                    fill_next   = FILL_W'(span_size_reg);
                    free_next   = span_size_reg;
                    set_up_next = 1'b1;
                    state_next  = kia_pkg::S_IDLE;
                end
            end
            kia_pkg::S_GET_MARK:
            begin
                m_raddr    = q_rdata;
                off_next   = q_rdata;
                state_next = kia_pkg::S_GET_CHK;
            end
            kia_pkg::S_GET_CHK:
            begin
                if ((off_reg < span_size_reg) && !m_rdata[0])
                begin
                    m_we        = 1'b1;
                    m_wdata     = 1'b1;
                    free_next   = free_dec;
                    done_next   = 1'b1;
                    status_next = kia_pkg::ST_OK;
                    issued_next = span_base_reg + 32'(off_reg);
                    state_next  = kia_pkg::S_IDLE;
                end
                else if (fill_reg != '0)
                begin
                    head_next  = head_inc;
                    fill_next  = fill_reg - 1'b1;
                    state_next = kia_pkg::S_GET_MARK;
                end
                else
                begin
                    done_next   = 1'b1;
                    status_next = kia_pkg::ST_EMPTY;
                    issued_next = '0;
                    state_next  = kia_pkg::S_IDLE;
                end
            end
            kia_pkg::S_MARK_CHK:
            begin
                done_next   = 1'b1;
                issued_next = '0;
                state_next  = kia_pkg::S_IDLE;
                if (kind_reg == kia_pkg::KIND_RESTORE)
                begin
                    if (!m_rdata[0])
                    begin
                        status_next = kia_pkg::ST_WRONG_MARK;
                    end
                    else if (32'(fill_reg) >= 32'(QUEUE_DEPTH))
                    begin
                        status_next = kia_pkg::ST_FULL;
                    end
                    else
                    begin
                        m_we        = 1'b1;
                        m_wdata     = 1'b0;
                        q_we        = 1'b1;
                        tail_next   = tail_inc;
                        fill_next   = fill_reg + 1'b1;
                        free_next   = free_reg + 1'b1;
                        status_next = kia_pkg::ST_OK;
                    end
                end
                else
                begin
                    if (m_rdata[0])
                    begin
                        status_next = kia_pkg::ST_WRONG_MARK;
                    end
                    else
                    begin
                        m_we        = 1'b1;
                        m_wdata     = 1'b1;
                        free_next   = free_dec;
                        status_next = kia_pkg::ST_OK;
                    end
                end
            end
            default:
            begin
                state_next = kia_pkg::S_IDLE;
            end
        endcase
    end

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(fill_reg) <= 32'(QUEUE_DEPTH))
        else $error("queue fill beyond depth");

    a_free_bound: assert property (@(posedge clk) disable iff (!rst_n)
        free_reg <= span_size_reg)
        else $error("free count beyond span size");

    a_no_key_on_error: assert property (@(posedge clk) disable iff (!rst_n)
        done && (status != kia_pkg::ST_OK) |-> (issued_key == '0))
        else $error("key issued with error status");

    a_fill_done: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == kia_pkg::S_FILL) && (state_next == kia_pkg::S_IDLE)
        |=> set_up_reg && (FILL_W'(span_size_reg) == fill_reg) && done)
        else $error("create sweep ended without set-up");

    a_set_up_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        set_up_reg |=> set_up_reg)
        else $error("set-up flag dropped");

endmodule
`default_nettype wire

// ===== sv/kia_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module kia_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [WIDTH-1:0]  wdata,
    input  wire logic [ADDR_W-1:0] raddr,
    output logic      [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire
